### rtl/msde_pkg.sv
// ----------------------------------------------------------------------------
// msde_pkg
// Types and constants shared by the multisynth divider register encoder.
// ----------------------------------------------------------------------------
package msde_pkg;

	localparam int VCO_W   = 30;
	localparam int FREQ_W  = 28;
	localparam int BASE_W  = 8;
	localparam int BYTE_W  = 8;
	localparam int FRAC_W  = 20;
	localparam int P1_W    = 18;
	localparam int P2_W    = 20;
	localparam int A_LO_W  = P1_W - 7;
	localparam int QUOT_W  = VCO_W + FRAC_W;
	localparam int ITERS   = QUOT_W / 2;
	localparam int ITER_W  = 5;
	localparam int WRITES  = 8;
	localparam int WR_W    = 3;

	localparam logic [VCO_W-1:0]    VCO_RESET    = 30'd864000000;
	localparam logic [FRAC_W-1:0]   DEN_C        = 20'hFFFFF;
	localparam logic [P1_W-1:0]     P1_OFFSET    = 18'd512;
	localparam logic [ITER_W-1:0]   ITER_LAST    = ITER_W'(ITERS - 1);
	// integer part is complete after VCO_W quotient bits, two per iteration
	localparam logic [ITER_W-1:0]   ITER_INT     = ITER_W'(VCO_W / 2 - 1);
	localparam logic [WR_W-1:0]     WR_LAST      = WR_W'(WRITES - 1);

	typedef struct packed {
		logic [BASE_W-1:0] reg_base;
		logic [FREQ_W-1:0] frequency_hz;
	} request_t;

	typedef struct packed {
		logic [BYTE_W-1:0] reg_addr;
		logic [BYTE_W-1:0] reg_data;
		logic              last_write;
	} reg_write_t;

	typedef struct packed {
		logic [BASE_W-1:0] reg_base;
		logic [A_LO_W-1:0] a_lo;
		logic [FRAC_W-1:0] b;
	} div_res_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

endpackage

### rtl/multisynth_divider_register_encoder_unit.sv
// ----------------------------------------------------------------------------
// multisynth_divider_register_encoder_unit
// Turns a frequency request into the eight multisynth register writes.
// ----------------------------------------------------------------------------
// For each request the radix-4 divider runs 25 iterations for the 50-bit
// quotient of vco * 2^20 / f; when the queue is fed, the next request
// starts as the emitter takes the result. The eight writes of one request
// play out while the divider works on the next.
// The oscillator register must only be written while the block is idle.
module multisynth_divider_register_encoder_unit
	import msde_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [VCO_W-1:0] cfg_wdata,
	input  logic             push,
	output logic             full,
	input  request_t         request,
	output logic             empty,
	input  logic             pop,
	output reg_write_t       reg_write
);

	logic [VCO_W-1:0] vco_q;
	logic             job_valid;
	logic             job_ready;
	request_t         job;
	logic             res_valid;
	logic             res_ready;
	div_res_t         res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vco_q <= VCO_RESET;
		end else if (cfg_we) begin
			vco_q <= cfg_wdata;
		end
	end

	msde_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job)
	);

	msde_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.vco      (vco_q),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	msde_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.empty    (empty),
		.pop      (pop),
		.reg_write(reg_write)
	);

endmodule

### rtl/msde_front.sv
// ----------------------------------------------------------------------------
// msde_front
// Accepts requests, maps a zero frequency to one and queues them for the
// divider.
// ----------------------------------------------------------------------------
module msde_front
	import msde_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  request_t request,
	output logic     job_valid,
	input  logic     job_ready,
	output request_t job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	request_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;
	request_t           cls;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign job_valid = (count_q != '0);
	assign job       = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = job_valid && job_ready;

	always_comb begin
		cls = request;
		if (request.frequency_hz == '0) begin
			cls.frequency_hz = FREQ_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/msde_divider.sv
// ----------------------------------------------------------------------------
// msde_divider
// Radix-4 restoring divider: forms vco * 2^20 / f, two quotient bits per
// cycle, and corrects the fraction for a denominator of 2^20 - 1.
// ----------------------------------------------------------------------------
module msde_divider
	import msde_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [VCO_W-1:0] vco,
	input  logic             job_valid,
	output logic             job_ready,
	input  request_t         job,
	output logic             res_valid,
	input  logic             res_ready,
	output div_res_t         res
);

	div_state_t          state_q;
	div_state_t          state_nxt;
	logic                start;
	logic [ITER_W-1:0]   it_q;
	logic [QUOT_W-1:0]   n_q;
	logic [FREQ_W-1:0]   r_q;
	logic [FREQ_W-1:0]   rem_q;
	logic [FREQ_W-1:0]   f_q;
	logic [BASE_W-1:0]   base_q;
	logic [FREQ_W:0]     t1;
	logic [FREQ_W:0]     t2;
	logic                ge1;
	logic                ge2;
	logic [FREQ_W-1:0]   r1;
	logic [FREQ_W-1:0]   r2;

	always_comb begin
		t1  = {r_q, n_q[QUOT_W-1]};
		ge1 = (t1 >= {1'b0, f_q});
		r1  = ge1 ? FREQ_W'(t1 - {1'b0, f_q}) : t1[FREQ_W-1:0];
		t2  = {r1, n_q[QUOT_W-2]};
		ge2 = (t2 >= {1'b0, f_q});
		r2  = ge2 ? FREQ_W'(t2 - {1'b0, f_q}) : t2[FREQ_W-1:0];
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (start) state_nxt = DIV_RUN;
			end
			DIV_RUN: begin
				if (it_q == ITER_LAST) state_nxt = DIV_DONE;
			end
			DIV_DONE: begin
				if (res_ready) state_nxt = start ? DIV_RUN : DIV_IDLE;
			end
			default: state_nxt = DIV_IDLE;
		endcase
	end

	always_comb begin
		job_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			DIV_IDLE: job_ready = 1'b1;
			DIV_DONE: begin
				res_valid = 1'b1;
				job_ready = res_ready;
			end
			default: begin
				job_ready = 1'b0;
				res_valid = 1'b0;
			end
		endcase
		start = job_valid && job_ready;
	end

	// remainder of vco / f sets whether the fraction drops by one
	assign res.reg_base = base_q;
	assign res.a_lo     = n_q[FRAC_W +: A_LO_W];
	assign res.b        = n_q[FRAC_W-1:0] - FRAC_W'(r_q < rem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= {vco, {FRAC_W{1'b0}}};
			r_q    <= '0;
			f_q    <= job.frequency_hz;
			base_q <= job.reg_base;
			it_q   <= '0;
		end else if (state_q == DIV_RUN) begin
			n_q  <= {n_q[QUOT_W-3:0], ge1, ge2};
			r_q  <= r2;
			it_q <= it_q + ITER_W'(1);
			if (it_q == ITER_INT) begin
				rem_q <= r2;
			end
		end
	end

endmodule

### rtl/msde_emitter.sv
// ----------------------------------------------------------------------------
// msde_emitter
// Builds p1 and p2 from the divider result and plays out the eight
// register writes of each item.
// ----------------------------------------------------------------------------
module msde_emitter
	import msde_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       res_valid,
	output logic       res_ready,
	input  div_res_t   res,
	output logic       empty,
	input  logic       pop,
	output reg_write_t reg_write
);

	logic              busy_q;
	logic [WR_W-1:0]   k_q;
	logic [BASE_W-1:0] base_q;
	logic [P1_W-1:0]   p1_q;
	logic [P2_W-1:0]   p2_q;
	logic              load;
	logic              take;
	logic [26:0]       x;
	logic [6:0]        q0;
	logic [FRAC_W:0]   s;
	logic              s_ge;
	logic [6:0]        q;
	logic [P2_W-1:0]   p2;
	logic [P1_W-1:0]   p1;
	logic [BYTE_W-1:0] data;

	// floor(128b / (2^20 - 1)) by folding the top bits back in
	always_comb begin
		x    = {res.b, 7'b0};
		q0   = x[26:FRAC_W];
		s    = {1'b0, x[FRAC_W-1:0]} + {{(FRAC_W-6){1'b0}}, q0};
		s_ge = (s >= {1'b0, DEN_C});
		p2   = s_ge ? P2_W'(s - {1'b0, DEN_C}) : s[P2_W-1:0];
		q    = q0 + 7'(s_ge);
		p1   = {res.a_lo, 7'b0} + {{(P1_W-7){1'b0}}, q} - P1_OFFSET;
	end

	assign empty     = !busy_q;
	assign take      = pop && busy_q;
	assign res_ready = !busy_q || (take && (k_q == WR_LAST));
	assign load      = res_valid && res_ready;

	always_comb begin
		case (k_q)
			3'd0:    data = DEN_C[15:8];
			3'd1:    data = DEN_C[7:0];
			3'd2:    data = {6'b0, p1_q[17:16]};
			3'd3:    data = p1_q[15:8];
			3'd4:    data = p1_q[7:0];
			3'd5:    data = {DEN_C[19:16], p2_q[19:16]};
			3'd6:    data = p2_q[15:8];
			default: data = p2_q[7:0];
		endcase
	end

	assign reg_write.reg_addr   = base_q + {{(BYTE_W-WR_W){1'b0}}, k_q};
	assign reg_write.reg_data   = data;
	assign reg_write.last_write = (k_q == WR_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (take) begin
			k_q <= k_q + WR_W'(1);
			if (k_q == WR_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			base_q <= res.reg_base;
			p1_q   <= p1;
			p2_q   <= p2;
		end
	end

endmodule

### rtl/msde_checker.sv
// ----------------------------------------------------------------------------
// msde_checker
// Port-level checks on the register write stream.
// ----------------------------------------------------------------------------
module msde_checker
	import msde_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input reg_write_t reg_write
);

	// a run does not break up before its last write
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !reg_write.last_write |=> !empty)
		else $error("write run broke off early");

	a_addr_steps: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !reg_write.last_write |=>
		reg_write.reg_addr == BYTE_W'($past(reg_write.reg_addr) + 8'd1))
		else $error("register address did not step by one");

	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && reg_write.last_write |=>
		empty || reg_write.reg_data == DEN_C[15:8])
		else $error("new run does not open with the p3 high byte");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(reg_write))
		else $error("waiting item changed");

endmodule

bind multisynth_divider_register_encoder_unit msde_checker u_msde_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.reg_write(reg_write)
);
